[sv/mst_pkg.sv]
// mst_pkg: field widths and the stored edge record for min_spanning_tree_cost
// no dependencies
`timescale 1ns / 1ps

package mst_pkg;

  localparam int unsigned NodeW   = 7;
  localparam int unsigned WeightW = 10;
  localparam int unsigned CostW   = 16;

  localparam logic [CostW-1:0] CostMax = {CostW{1'b1}};

  typedef struct packed {
    logic [NodeW-1:0]   node_a;
    logic [NodeW-1:0]   node_b;
    logic [WeightW-1:0] weight;
  } edge_t;

endpackage

[sv/min_spanning_tree_cost.sv]
// min_spanning_tree_cost: minimum spanning tree cost by Kruskal with union-find
// depends on mst_pkg
`timescale 1ns / 1ps

// Edges are taken one per cycle and written to an edge memory, and the
// distinct endpoints are counted. The request that carries last_edge starts
// the tree search and the input stalls until it ends. Each tree step is a
// selection scan over the edge memory (one read per cycle on its single
// read port) for the lightest edge not yet taken, followed by two root
// walks through the parent memory and a join step. Graphs with fewer than
// two nodes skip the search and go straight to the result. The result waits
// in an output register, and loading of the next graph may begin while it
// waits. All graph state is cleared in the cycle the result is issued; no
// clearing pass is needed.
module min_spanning_tree_cost #(
  parameter int unsigned MAX_EDGES = 64,
  parameter int unsigned MAX_NODES = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mst_pkg::NodeW-1:0]    node_a_i,
  input  logic [mst_pkg::NodeW-1:0]    node_b_i,
  input  logic [mst_pkg::WeightW-1:0]  weight_i,
  input  logic                         last_edge_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mst_pkg::CostW-1:0]    total_cost_o,
  output logic                         impossible_o
);

  // node ids are 7 bits wide, so no more than 128 nodes can appear
  localparam int unsigned IdSpan = 1 << mst_pkg::NodeW;
  localparam int unsigned Nodes  = (MAX_NODES < IdSpan) ? MAX_NODES : IdSpan;
  localparam int unsigned NW     = $clog2(Nodes);
  localparam int unsigned CW     = $clog2(Nodes + 1);
  localparam int unsigned EW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned WW     = mst_pkg::WeightW;

  localparam logic [mst_pkg::NodeW:0] NodeLim  = (mst_pkg::NodeW + 1)'(Nodes);
  localparam logic [ECW-1:0]          EdgeLim  = ECW'(MAX_EDGES);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StStart = 3'd1;
  localparam logic [2:0] StScan  = 3'd2;
  localparam logic [2:0] StFind  = 3'd3;
  localparam logic [2:0] StPwait = 3'd4;
  localparam logic [2:0] StJoin  = 3'd5;
  localparam logic [2:0] StFin   = 3'd6;

  logic [2:0] state_q, state_d;

  // memories
  mst_pkg::edge_t edge_mem [MAX_EDGES];
  logic [NW-1:0]  par_mem  [Nodes];
  mst_pkg::edge_t edge_rd_q;
  logic [NW-1:0]  par_rd_q;

  // graph state
  logic [ECW-1:0]   edge_count_q;
  logic [CW-1:0]    node_count_q;
  logic [Nodes-1:0] seen_q;
  logic [Nodes-1:0] linked_q;

  // selection scan
  logic [ECW-1:0] scan_idx_q;
  logic           pend_q;
  logic [EW-1:0]  pend_idx_q;
  logic           found_q;
  logic [WW-1:0]  best_w_q;
  logic [EW-1:0]  best_idx_q;
  logic [NW-1:0]  best_a_q;
  logic [NW-1:0]  best_b_q;
  logic           has_last_q;
  logic [WW-1:0]  last_w_q;
  logic [EW-1:0]  last_idx_q;

  // root walk and join
  logic [NW-1:0]            cur_q;
  logic                     phase_b_q;
  logic [NW-1:0]            ru_q;
  logic [NW-1:0]            rv_q;
  logic [CW-1:0]            joins_q;
  logic [mst_pkg::CostW-1:0] total_q;
  logic                     ok_q;

  // output register
  logic                      out_valid_q;
  logic [mst_pkg::CostW-1:0] out_cost_q;
  logic                      out_imp_q;

  // input side
  logic          in_acc;
  logic          edge_ok;
  logic [NW-1:0] a_idx, b_idx;
  logic          new_a, new_b;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && (state_q == StIdle);
  assign edge_ok    = (edge_count_q < EdgeLim) &&
                      ({1'b0, node_a_i} < NodeLim) && ({1'b0, node_b_i} < NodeLim);
  assign a_idx      = node_a_i[NW-1:0];
  assign b_idx      = node_b_i[NW-1:0];
  assign new_a      = !seen_q[a_idx];
  assign new_b      = !seen_q[b_idx] && (a_idx != b_idx);

  // scan compare on the registered edge read
  logic scan_issue, scan_done, above_last, below_best;
  assign scan_issue = (state_q == StScan) && (scan_idx_q < edge_count_q);
  assign scan_done  = (state_q == StScan) && !scan_issue && !pend_q;
  assign above_last = !has_last_q || ({edge_rd_q.weight, pend_idx_q} > {last_w_q, last_idx_q});
  assign below_best = !found_q || ({edge_rd_q.weight, pend_idx_q} < {best_w_q, best_idx_q});

  // join arithmetic
  logic [CW-1:0]           joins_nx;
  logic [mst_pkg::CostW:0] sum;
  logic [mst_pkg::CostW-1:0] total_nx;
  assign joins_nx = joins_q + CW'(1);
  assign sum      = {1'b0, total_q} + (mst_pkg::CostW + 1)'(best_w_q);
  assign total_nx = sum[mst_pkg::CostW] ? mst_pkg::CostMax : sum[mst_pkg::CostW-1:0];

  logic fin_go;
  assign fin_go = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_acc && last_edge_i) state_d = StStart;
      end
      StStart: begin
        state_d = (node_count_q < CW'(2)) ? StFin : StScan;
      end
      StScan: begin
        if (scan_done) state_d = found_q ? StFind : StFin;
      end
      StFind: begin
        if (linked_q[cur_q]) begin
          state_d = StPwait;
        end else if (phase_b_q) begin
          state_d = StJoin;
        end
      end
      StPwait: state_d = StFind;
      StJoin: begin
        if ((ru_q != rv_q) && (joins_nx == node_count_q - CW'(1))) begin
          state_d = StFin;
        end else begin
          state_d = StScan;
        end
      end
      StFin: begin
        if (fin_go) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // memory ports
  always_ff @(posedge clk_i) begin
    if (in_acc && edge_ok) begin
      edge_mem[edge_count_q[EW-1:0]] <= '{node_a: node_a_i, node_b: node_b_i, weight: weight_i};
    end
    edge_rd_q <= edge_mem[scan_idx_q[EW-1:0]];
    if ((state_q == StJoin) && (ru_q != rv_q)) begin
      par_mem[ru_q] <= rv_q;
    end
    par_rd_q <= par_mem[cur_q];
  end

  // sequencer datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      edge_count_q <= '0;
      node_count_q <= '0;
      seen_q       <= '0;
      linked_q     <= '0;
      scan_idx_q   <= '0;
      pend_q       <= 1'b0;
      found_q      <= 1'b0;
      has_last_q   <= 1'b0;
      phase_b_q    <= 1'b0;
      joins_q      <= '0;
      total_q      <= '0;
      ok_q         <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i && (state_q != StFin)) out_valid_q <= 1'b0;

      case (state_q)
        StIdle: begin
          if (in_acc && edge_ok) begin
            edge_count_q <= edge_count_q + ECW'(1);
            node_count_q <= node_count_q + CW'(new_a) + CW'(new_b);
            seen_q       <= seen_q | (Nodes'(1) << a_idx) | (Nodes'(1) << b_idx);
          end
        end
        StStart: begin
          scan_idx_q <= '0;
          pend_q     <= 1'b0;
          found_q    <= 1'b0;
          has_last_q <= 1'b0;
          joins_q    <= '0;
          total_q    <= '0;
          ok_q       <= 1'b0;
        end
        StScan: begin
          pend_q     <= scan_issue;
          pend_idx_q <= scan_idx_q[EW-1:0];
          if (scan_issue) scan_idx_q <= scan_idx_q + ECW'(1);
          if (pend_q && above_last && below_best) begin
            found_q    <= 1'b1;
            best_w_q   <= edge_rd_q.weight;
            best_idx_q <= pend_idx_q;
            best_a_q   <= edge_rd_q.node_a[NW-1:0];
            best_b_q   <= edge_rd_q.node_b[NW-1:0];
          end
          if (scan_done) begin
            cur_q     <= best_a_q;
            phase_b_q <= 1'b0;
          end
        end
        StFind: begin
          // an unlinked node is its own root
          if (!linked_q[cur_q]) begin
            if (!phase_b_q) begin
              ru_q      <= cur_q;
              cur_q     <= best_b_q;
              phase_b_q <= 1'b1;
            end else begin
              rv_q <= cur_q;
            end
          end
        end
        StPwait: begin
          cur_q <= par_rd_q;
        end
        StJoin: begin
          if (ru_q != rv_q) begin
            linked_q[ru_q] <= 1'b1;
            joins_q        <= joins_nx;
            total_q        <= total_nx;
            if (joins_nx == node_count_q - CW'(1)) ok_q <= 1'b1;
          end
          // next scan looks for the lightest edge past this one
          has_last_q <= 1'b1;
          last_w_q   <= best_w_q;
          last_idx_q <= best_idx_q;
          found_q    <= 1'b0;
          scan_idx_q <= '0;
          pend_q     <= 1'b0;
        end
        StFin: begin
          if (fin_go) begin
            out_valid_q  <= 1'b1;
            out_cost_q   <= ok_q ? total_q : '0;
            out_imp_q    <= !ok_q;
            edge_count_q <= '0;
            node_count_q <= '0;
            seen_q       <= '0;
            linked_q     <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign total_cost_o = out_cost_q;
  assign impossible_o = out_imp_q;

endmodule

[tb/tb.sv]
// tb: self-checking bench for min_spanning_tree_cost, directed table then random graphs
// depends on mst_pkg and min_spanning_tree_cost
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MaxEdges    = 64;
  localparam int unsigned MaxNodes    = 128;
  localparam int unsigned ItemsTarget = 1350;
  localparam int unsigned CycleLimit  = 2_000_000;
  localparam int unsigned TailCycles  = 200;

  typedef struct packed {
    logic [mst_pkg::CostW-1:0] total_cost;
    logic                      impossible;
  } mst_result_t;

  typedef struct packed {
    logic [mst_pkg::NodeW-1:0]   node_a;
    logic [mst_pkg::NodeW-1:0]   node_b;
    logic [mst_pkg::WeightW-1:0] weight;
    logic                        last_edge;
    logic                        known;       // expected result typed in below
    logic [mst_pkg::CostW-1:0]   total_cost;
    logic                        impossible;
  } plan_row_t;

  typedef enum int unsigned {
    GraphSmall,
    GraphMedium,
    GraphOversize,
    GraphNoise
  } graph_kind_e;

  localparam int unsigned PlanLen = 21;
  localparam plan_row_t DirectedPlan [PlanLen] = '{
    // widest node ids, heaviest edge
    '{7'd0,   7'd127, 10'd1023, 1'b1, 1'b1, 16'd1023, 1'b0},
    // self loop alone: one node only
    '{7'd5,   7'd5,   10'd7,    1'b1, 1'b1, 16'd0,    1'b1},
    '{7'd10,  7'd11,  10'd0,    1'b1, 1'b1, 16'd0,    1'b0},
    // two separate components
    '{7'd1,   7'd2,   10'd5,    1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd3,   7'd4,   10'd6,    1'b1, 1'b1, 16'd0,    1'b1},
    // triangle of equal weights
    '{7'd20,  7'd21,  10'd3,    1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd21,  7'd22,  10'd3,    1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd20,  7'd22,  10'd3,    1'b1, 1'b1, 16'd6,    1'b0},
    // cycle of maximum weights
    '{7'd127, 7'd0,   10'd1023, 1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd0,   7'd1,   10'd1023, 1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd1,   7'd127, 10'd1023, 1'b1, 1'b1, 16'd2046, 1'b0},
    // mixed graph with a self loop inside
    '{7'd30,  7'd31,  10'd100,  1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd31,  7'd32,  10'd50,   1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd33,  7'd33,  10'd1,    1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd30,  7'd32,  10'd20,   1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd32,  7'd33,  10'd900,  1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd30,  7'd33,  10'd899,  1'b1, 1'b0, 16'd0,    1'b0},
    // alternating bit patterns, parallel edge reversed
    '{7'd85,  7'd42,  10'd512,  1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd42,  7'd85,  10'd511,  1'b1, 1'b1, 16'd511,  1'b0},
    // parallel edges of equal weight
    '{7'd64,  7'd63,  10'd1,    1'b0, 1'b0, 16'd0,    1'b0},
    '{7'd63,  7'd64,  10'd1,    1'b1, 1'b1, 16'd1,    1'b0}
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic [mst_pkg::NodeW-1:0]   node_a_i;
  logic [mst_pkg::NodeW-1:0]   node_b_i;
  logic [mst_pkg::WeightW-1:0] weight_i;
  logic                        last_edge_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic [mst_pkg::CostW-1:0]   total_cost_o;
  logic                        impossible_o;

  min_spanning_tree_cost #(
    .MAX_EDGES(MaxEdges),
    .MAX_NODES(MaxNodes)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .node_a_i    (node_a_i),
    .node_b_i    (node_b_i),
    .weight_i    (weight_i),
    .last_edge_i (last_edge_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .total_cost_o(total_cost_o),
    .impossible_o(impossible_o)
  );

  // graph under construction, as the block should hold it
  mst_pkg::edge_t            graph_edges [MaxEdges];
  int unsigned               graph_edge_cnt;
  logic                      node_seen [MaxNodes];
  int unsigned               node_cnt;
  logic [mst_pkg::NodeW-1:0] root_link [MaxNodes];

  mst_result_t tree_costs_q[$];
  int unsigned fault_cnt;
  int unsigned cycle_cnt;
  int unsigned items_sent;
  logic        quiet;

  always #1 clk_i = ~clk_i;

  function automatic void mark_node(input logic [mst_pkg::NodeW-1:0] n);
    if (!node_seen[n]) begin
      node_seen[n] = 1'b1;
      root_link[n] = n;
      node_cnt++;
    end
  endfunction

  function automatic logic [mst_pkg::NodeW-1:0] find_root(input logic [mst_pkg::NodeW-1:0] n);
    int unsigned hops;
    hops = 0;
    while (root_link[n] != n && hops < MaxNodes) begin
      n = root_link[n];
      hops++;
    end
    return n;
  endfunction

  // loads one edge; on the last edge runs kruskal and clears the graph
  function automatic void kruskal_step(input mst_pkg::edge_t e, input logic last,
                                       output logic fires, output mst_result_t res);
    int unsigned               order [MaxEdges];
    int unsigned               i;
    int unsigned               j;
    int unsigned               joins;
    int unsigned               sum;
    logic [mst_pkg::NodeW-1:0] ru;
    logic [mst_pkg::NodeW-1:0] rv;
    logic                      spanned;
    fires   = 1'b0;
    res     = '0;
    joins   = 0;
    sum     = 0;
    spanned = 1'b0;
    // a full store drops the edge, endpoints stay unseen
    if (graph_edge_cnt < MaxEdges) begin
      graph_edges[graph_edge_cnt] = e;
      graph_edge_cnt++;
      mark_node(e.node_a);
      mark_node(e.node_b);
    end
    if (!last) return;
    for (i = 0; i < graph_edge_cnt; i++) begin
      j = i;
      while (j > 0 && graph_edges[order[j-1]].weight > graph_edges[i].weight) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    if (node_cnt >= 2) begin
      for (i = 0; i < graph_edge_cnt; i++) begin
        ru = find_root(graph_edges[order[i]].node_a);
        rv = find_root(graph_edges[order[i]].node_b);
        if (ru != rv) begin
          root_link[ru] = rv;
          joins++;
          sum += graph_edges[order[i]].weight;
          if (joins == node_cnt - 1) begin
            spanned = 1'b1;
            break;
          end
        end
      end
    end
    fires = 1'b1;
    if (spanned) begin
      res.total_cost = (sum > mst_pkg::CostMax) ? mst_pkg::CostMax : sum[mst_pkg::CostW-1:0];
    end else begin
      res.impossible = 1'b1;
    end
    graph_edge_cnt = 0;
    node_cnt       = 0;
    for (i = 0; i < MaxNodes; i++) begin
      node_seen[i] = 1'b0;
    end
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_edge(input mst_pkg::edge_t e, input logic last, input logic known,
                           input mst_result_t known_res);
    logic        fires;
    mst_result_t res;
    while (!quiet && $urandom_range(0, 99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    node_a_i    <= e.node_a;
    node_b_i    <= e.node_b;
    weight_i    <= e.weight;
    last_edge_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    kruskal_step(e, last, fires, res);
    if (fires) tree_costs_q = {tree_costs_q, (known ? known_res : res)};
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (tree_costs_q.size() != 0);
  endtask

  function automatic logic [mst_pkg::WeightW-1:0] pick_weight(input int unsigned mode);
    case (mode)
      0: return mst_pkg::WeightW'($urandom_range(0, 3));    // many ties
      1: return ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: return mst_pkg::WeightW'($urandom_range(0, 1023));
    endcase
  endfunction

  // mostly connected graphs: a random tree plus extra edges, shuffled
  task automatic send_graph(input graph_kind_e kind);
    logic [mst_pkg::NodeW-1:0] ids[$];
    mst_pkg::edge_t            edges[$];
    mst_pkg::edge_t            tmp;
    int unsigned               n_nodes;
    int unsigned               n_extra;
    int unsigned               wmode;
    int unsigned               k;
    int unsigned               pick;
    wmode = $urandom_range(0, 4);
    case (kind)
      GraphOversize: begin
        n_nodes = $urandom_range(40, 65);
        n_extra = $urandom_range(2, 8);
      end
      GraphMedium: begin
        n_nodes = $urandom_range(8, 20);
        n_extra = $urandom_range(0, 10);
      end
      GraphNoise: begin
        n_nodes = 0;
        n_extra = $urandom_range(1, 5);
      end
      default: begin
        n_nodes = $urandom_range(2, 8);
        n_extra = $urandom_range(0, 4);
      end
    endcase
    for (k = 0; k < n_nodes; k++) begin
      ids = {ids, mst_pkg::NodeW'($urandom_range(0, 127))};
    end
    // a dropped tree edge now and then leaves the graph split
    for (k = 1; k < n_nodes; k++) begin
      if ($urandom_range(0, 19) != 0) begin
        tmp.node_a = ids[k];
        tmp.node_b = ids[$urandom_range(0, k - 1)];
        tmp.weight = pick_weight(wmode);
        edges = {edges, tmp};
      end
    end
    for (k = 0; k < n_extra; k++) begin
      if (kind == GraphNoise) begin
        tmp.node_a = mst_pkg::NodeW'($urandom_range(0, 127));
        tmp.node_b = mst_pkg::NodeW'($urandom_range(0, 127));
      end else begin
        tmp.node_a = ids[$urandom_range(0, n_nodes - 1)];
        tmp.node_b = ids[$urandom_range(0, n_nodes - 1)];
      end
      tmp.weight = pick_weight(wmode);
      edges = {edges, tmp};
    end
    if (edges.size() == 0) begin
      tmp.node_a = ids[0];
      tmp.node_b = ids[n_nodes - 1];
      tmp.weight = pick_weight(wmode);
      edges = {edges, tmp};
    end
    for (k = edges.size() - 1; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tmp = edges[k];
      edges[k] = edges[pick];
      edges[pick] = tmp;
      if ($urandom_range(0, 1) != 0) begin
        edges[k].node_a = tmp.node_b;
        edges[k].node_b = tmp.node_a;
      end
    end
    // past a full store the closing edge is dropped but still starts the search
    if (kind == GraphOversize) begin
      tmp.node_a = mst_pkg::NodeW'($urandom_range(0, 127));
      tmp.node_b = mst_pkg::NodeW'($urandom_range(0, 127));
      tmp.weight = pick_weight(wmode);
      edges = {edges, tmp};
    end
    for (k = 0; k < edges.size(); k++) begin
      send_edge(edges[k], k == edges.size() - 1, 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !quiet && ($urandom_range(0, 99) < 33);
  end

  always @(posedge clk_i) begin
    mst_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (tree_costs_q.size() == 0) begin
        $error("result with no request pending: total_cost=%0d impossible=%0b",
               total_cost_o, impossible_o);
        fault_cnt++;
      end else begin
        want = tree_costs_q.pop_front();
        if (total_cost_o !== want.total_cost) begin
          $error("total_cost mismatch: expected %0d, actual %0d", want.total_cost, total_cost_o);
          fault_cnt++;
        end
        if (impossible_o !== want.impossible) begin
          $error("impossible mismatch: expected %0b, actual %0b", want.impossible, impossible_o);
          fault_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int unsigned r;
    int unsigned graph_idx;
    graph_kind_e kind;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    node_a_i       = '0;
    node_b_i       = '0;
    weight_i       = '0;
    last_edge_i    = 1'b0;
    out_stall_i    = 1'b0;
    quiet          = 1'b0;
    fault_cnt      = 0;
    cycle_cnt      = 0;
    items_sent     = 0;
    graph_edge_cnt = 0;
    node_cnt       = 0;
    for (r = 0; r < MaxNodes; r++) begin
      node_seen[r] = 1'b0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (r = 0; r < PlanLen; r++) begin
      send_edge('{node_a: DirectedPlan[r].node_a, node_b: DirectedPlan[r].node_b,
                  weight: DirectedPlan[r].weight},
                DirectedPlan[r].last_edge, DirectedPlan[r].known,
                '{total_cost: DirectedPlan[r].total_cost,
                  impossible: DirectedPlan[r].impossible});
    end
    hold_until_drained();

    graph_idx = 0;
    while (items_sent < ItemsTarget) begin
      quiet = (items_sent >= 500 && items_sent < 750);
      if (graph_idx == 2 || graph_idx % 37 == 20) kind = GraphOversize;
      else if ($urandom_range(0, 9) == 0) kind = GraphNoise;
      else if ($urandom_range(0, 7) == 0) kind = GraphMedium;
      else kind = GraphSmall;
      send_graph(kind);
      if (graph_idx == 60) hold_until_drained();
      graph_idx++;
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (tree_costs_q.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
